>>> src/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
package bba_pkg;

  // Fixed field widths of the transfer payloads
  localparam int SLOT_W   = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int MAP_W    = 8;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [MAP_W-1:0]   map_byte_t;

  // Map byte values: all slots in use, and the first slot of a byte
  localparam map_byte_t FULL_BYTE = 8'hFF;
  localparam map_byte_t TOP_BIT   = 8'h80;

  // Request kinds
  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_ALREADY_FREE = 2'd2
  } status_t;

endpackage

>>> src/block_bitmap_allocator.sv
// Next-fit block allocator over a byte-wide free map held in one RAM.
//
// After reset the block clears its free map, one byte per cycle, and accepts no
// request meanwhile. A free goes through one map read, one read-modify-write and
// the load of the output register, which waits while the output register still
// holds an untaken result. An allocate scans the map from the byte of the last
// granted slot, stepping over full map bytes; the scan examines one byte per
// cycle, as the map RAM has a single read port. An allocate with no free slot
// left skips the scan. A finished result waits in the output register while the
// next request is taken.
module block_bitmap_allocator #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  bba_pkg::slot_t          in_slot,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output bba_pkg::slot_t          out_granted_slot,
  output bba_pkg::status_t        out_status,
  output bba_pkg::count_t         out_free_left
);

  localparam int MAP_BYTES = NUM_BLOCKS / 8;
  localparam int TOTAL     = MAP_BYTES * 8;
  localparam int BYTE_W    = $clog2(MAP_BYTES);
  localparam int LAST_W    = BYTE_W + 3;
  localparam int CNT_W     = $clog2(TOTAL + 1);
  localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(MAP_BYTES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACHK,
    S_FCHK,
    S_PUT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [BYTE_W-1:0]      clr_r, clr_nxt;
  logic [BYTE_W-1:0]      byte_r, byte_nxt;
  logic [BYTE_W-1:0]      scan_left_r, scan_left_nxt;
  logic [LAST_W-1:0]      last_r, last_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  bba_pkg::slot_t         slot_r, slot_nxt;
  bba_pkg::slot_t         res_slot_r, res_slot_nxt;
  bba_pkg::status_t       res_status_r, res_status_nxt;
  bba_pkg::count_t        res_left_r, res_left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bba_pkg::slot_t         out_slot_r, out_slot_nxt;
  bba_pkg::status_t       out_status_r, out_status_nxt;
  bba_pkg::count_t        out_left_r, out_left_nxt;

  logic                   wr_en;
  logic [BYTE_W-1:0]      wr_addr;
  bba_pkg::map_byte_t     wr_data;
  bba_pkg::map_byte_t     rd_data;
  logic [2:0]             free_pos;
  bba_pkg::map_byte_t     free_mask;
  logic                   slot_off_map;

  bba_ram #(
    .WIDTH (bba_pkg::MAP_W),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (byte_nxt),
    .rd_data (rd_data)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;
  assign out_free_left    = out_left_r;

  // Find the first clear bit from the top of the byte under test
  always_comb begin
    free_pos = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!rd_data[7-k]) begin
        free_pos = 3'(k);
      end
    end
  end

  assign free_mask    = bba_pkg::TOP_BIT >> (state_r == S_FCHK ? slot_r[2:0] : free_pos);
  assign slot_off_map = 32'(in_slot[bba_pkg::SLOT_W-1:3]) >= MAP_BYTES;

  // Sequencer: next state, map writes and result staging
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    byte_nxt       = byte_r;
    scan_left_nxt  = scan_left_r;
    last_nxt       = last_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    res_left_nxt   = res_left_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_left_nxt   = out_left_r;
    out_valid_nxt  = out_valid_r;
    wr_en          = 1'b0;
    wr_addr        = byte_r;
    wr_data        = '0;

    // drop the result once the transfer completes
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        if (clr_r == LAST_BYTE) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + BYTE_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          slot_nxt = in_slot;
          if (in_kind == bba_pkg::KIND_FREE) begin
            if (slot_off_map) begin
              res_slot_nxt   = in_slot;
              res_status_nxt = bba_pkg::ST_ALREADY_FREE;
              res_left_nxt   = bba_pkg::count_t'(count_r);
              state_nxt      = S_PUT;
            end else begin
              byte_nxt  = BYTE_W'(in_slot[bba_pkg::SLOT_W-1:3]);
              state_nxt = S_FCHK;
            end
          end else if (count_r == '0) begin
            res_slot_nxt   = '0;
            res_status_nxt = bba_pkg::ST_NO_FREE;
            res_left_nxt   = '0;
            state_nxt      = S_PUT;
          end else begin
            // start the scan at the byte of the last granted slot
            byte_nxt      = last_r[LAST_W-1:3];
            scan_left_nxt = LAST_BYTE;
            state_nxt     = S_ACHK;
          end
        end
      end

      S_ACHK: begin
        if (rd_data != bba_pkg::FULL_BYTE) begin
          wr_en          = 1'b1;
          wr_data        = rd_data | free_mask;
          last_nxt       = {byte_r, free_pos};
          count_nxt      = count_r - CNT_W'(1);
          res_slot_nxt   = bba_pkg::slot_t'({byte_r, free_pos});
          res_status_nxt = bba_pkg::ST_OK;
          res_left_nxt   = bba_pkg::count_t'(count_r - CNT_W'(1));
          state_nxt      = S_PUT;
        end else if (scan_left_r == '0) begin
          res_slot_nxt   = '0;
          res_status_nxt = bba_pkg::ST_NO_FREE;
          res_left_nxt   = '0;
          state_nxt      = S_PUT;
        end else begin
          // advance to the next byte, wrapping at the end of the map
          byte_nxt      = (byte_r == LAST_BYTE) ? '0 : byte_r + BYTE_W'(1);
          scan_left_nxt = scan_left_r - BYTE_W'(1);
        end
      end

      S_FCHK: begin
        res_slot_nxt = slot_r;
        if ((rd_data & free_mask) == '0) begin
          res_status_nxt = bba_pkg::ST_ALREADY_FREE;
          res_left_nxt   = bba_pkg::count_t'(count_r);
        end else begin
          wr_en          = 1'b1;
          wr_data        = rd_data & ~free_mask;
          count_nxt      = count_r + CNT_W'(1);
          res_status_nxt = bba_pkg::ST_OK;
          res_left_nxt   = bba_pkg::count_t'(count_r + CNT_W'(1));
        end
        state_nxt = S_PUT;
      end

      S_PUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_slot_nxt   = res_slot_r;
          out_status_nxt = res_status_r;
          out_left_nxt   = res_left_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      last_r      <= '0;
      count_r     <= CNT_W'(TOTAL);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      last_r      <= last_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r       <= byte_nxt;
    scan_left_r  <= scan_left_nxt;
    slot_r       <= slot_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_left_r   <= res_left_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_left_r   <= out_left_nxt;
  end

endmodule

>>> src/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the next-fit block bitmap allocator.
module tb;
  import bba_pkg::*;

  localparam int NUM_BLOCKS     = 4096;
  localparam int MAP_BYTES      = NUM_BLOCKS / 8;
  localparam int LAST_BYTE      = MAP_BYTES - 1;
  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 400;
  localparam int DRAIN_CYCLES   = 10;
  localparam int NUM_DIRECTED   = 22;

  // One result transfer
  typedef struct {
    slot_t   slot;
    status_t status;
    count_t  left;
  } alloc_result_t;

  // One directed request; the result is typed in only where it is obvious
  typedef struct {
    kind_t   kind;
    slot_t   slot;
    bit      typed;
    slot_t   exp_slot;
    status_t exp_status;
    count_t  exp_left;
  } request_row_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  logic    in_kind;
  slot_t   in_slot;
  logic    out_valid;
  logic    out_ready;
  slot_t   out_granted_slot;
  status_t out_status;
  count_t  out_free_left;

  // Shadow allocator state
  map_byte_t slot_map [MAP_BYTES];
  count_t    free_slots;
  slot_t     last_slot;
  slot_t     held_slots [$];

  alloc_result_t expected_results [$];

  int sender_idle_pct;
  int recv_stall_pct;
  bit hold_pending;
  int hold_left;
  int idle_cycles;
  int n_errors;
  int n_requests;
  int n_checked;
  int n_no_free;
  int n_double_free;
  int min_free;

  request_row_t directed_rows [NUM_DIRECTED] = '{
    '{KIND_ALLOC, 12'd0,    1'b1, 12'd0,    ST_OK,           13'd4095},
    '{KIND_ALLOC, 12'hFFF,  1'b1, 12'd1,    ST_OK,           13'd4094},
    '{KIND_FREE,  12'd0,    1'b1, 12'd0,    ST_OK,           13'd4095},
    '{KIND_FREE,  12'd1,    1'b1, 12'd1,    ST_OK,           13'd4096},
    '{KIND_FREE,  12'd1,    1'b1, 12'd1,    ST_ALREADY_FREE, 13'd4096},
    '{KIND_FREE,  12'd4095, 1'b1, 12'd4095, ST_ALREADY_FREE, 13'd4096},
    '{KIND_FREE,  12'd2048, 1'b1, 12'd2048, ST_ALREADY_FREE, 13'd4096},
    '{KIND_FREE,  12'hAAA,  1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_FREE,  12'h555,  1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'hAAA,  1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'h555,  1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_FREE,  12'd3,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_FREE,  12'd8,    1'b0, 12'd0,    ST_OK,           13'd0},
    '{KIND_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK,           13'd0}
  };

  block_bitmap_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .out_free_left    (out_free_left)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Next-fit allocate from the last granted byte, or release one slot
  function automatic void predict_request(input kind_t kind, input slot_t slot,
                                          output alloc_result_t res);
    int        byte_at;
    int        pos;
    map_byte_t v;
    map_byte_t mask;
    bit        found;

    res = '{slot: slot_t'(0), status: ST_NO_FREE, left: count_t'(0)};
    if (kind == KIND_ALLOC) begin
      found   = 1'b0;
      byte_at = int'(last_slot) / 8;
      if (free_slots != 0) begin
        for (int visited = 0; visited < MAP_BYTES && !found; visited++) begin
          v = slot_map[byte_at];
          if (v != FULL_BYTE) begin
            pos  = 0;
            mask = TOP_BIT;
            while ((v & mask) != 0) begin
              mask = mask >> 1;
              pos++;
            end
            slot_map[byte_at] = v | mask;
            last_slot  = slot_t'(byte_at * 8 + pos);
            free_slots = free_slots - 1'b1;
            held_slots.push_back(last_slot);
            res   = '{slot: last_slot, status: ST_OK, left: free_slots};
            found = 1'b1;
          end else begin
            byte_at = (byte_at == LAST_BYTE) ? 0 : byte_at + 1;
          end
        end
      end
      if (!found) n_no_free++;
    end else begin
      byte_at = int'(slot) / 8;
      mask    = TOP_BIT >> slot[2:0];
      if ((slot_map[byte_at] & mask) == 0) begin
        res = '{slot: slot, status: ST_ALREADY_FREE, left: free_slots};
        n_double_free++;
      end else begin
        slot_map[byte_at] = slot_map[byte_at] & ~mask;
        free_slots = free_slots + 1'b1;
        foreach (held_slots[i]) begin
          if (held_slots[i] == slot) begin
            held_slots.delete(i);
            break;
          end
        end
        res = '{slot: slot, status: ST_OK, left: free_slots};
      end
    end
    if (int'(free_slots) < min_free) min_free = int'(free_slots);
  endfunction

  // Offer one request, hold it until the transfer, then predict it
  task automatic send_request(input kind_t kind, input slot_t slot,
                              output alloc_result_t res);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_slot  <= slot;
    do @(posedge clk); while (!in_ready);
    predict_request(kind, slot, res);
    n_requests++;
  endtask

  // Drop valid in each cycle with the chosen idle share
  task automatic sender_gap();
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic issue(input kind_t kind, input slot_t slot);
    alloc_result_t res;
    send_request(kind, slot, res);
    expected_results.push_back(res);
    sender_gap();
  endtask

  // Mostly allocates and frees of held slots, some frees of arbitrary slots
  task automatic issue_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45 || (pick < 85 && held_slots.size() == 0))
      issue(KIND_ALLOC, slot_t'($urandom));
    else if (pick < 85)
      issue(KIND_FREE, held_slots[$urandom_range(held_slots.size() - 1)]);
    else
      issue(KIND_FREE, slot_t'($urandom_range(NUM_BLOCKS - 1)));
  endtask

  // Result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_pending) begin
      hold_left    = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: granted_slot %0d status %0d free_left %0d",
               out_granted_slot, out_status, out_free_left);
        n_errors++;
      end else begin
        exp_res = expected_results.pop_front();
        n_checked++;
        if (out_granted_slot !== exp_res.slot) begin
          $error("granted_slot: expected %0d, actual %0d", exp_res.slot, out_granted_slot);
          n_errors++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_status);
          n_errors++;
        end
        if (out_free_left !== exp_res.left) begin
          $error("free_left: expected %0d, actual %0d", exp_res.left, out_free_left);
          n_errors++;
        end
      end
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer in %0d cycles, %0d results outstanding",
                 idle_cycles, expected_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    alloc_result_t res;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_ALLOC;
    in_slot         = '0;
    out_ready       = 1'b0;
    hold_pending    = 1'b0;
    hold_left       = 0;
    idle_cycles     = 0;
    n_errors        = 0;
    n_requests      = 0;
    n_checked       = 0;
    n_no_free       = 0;
    n_double_free   = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    foreach (slot_map[i]) slot_map[i] = '0;
    free_slots = count_t'(NUM_BLOCKS);
    last_slot  = '0;
    min_free   = NUM_BLOCKS;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, double frees, filling the first byte
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].slot, res);
      if (directed_rows[i].typed)
        res = '{slot: directed_rows[i].exp_slot, status: directed_rows[i].exp_status,
                left: directed_rows[i].exp_left};
      expected_results.push_back(res);
    end

    // Random traffic under four idling patterns; long hold-off in the first
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        if (phase == 0 && n == 30) hold_pending = 1'b1;
        issue_random();
      end
    end

    // Finish with a short stretch of mixed traffic
    sender_idle_pct = 34;
    recv_stall_pct  = 34;
    repeat (40) issue_random();
    in_valid <= 1'b0;

    // Drain outstanding results
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d checked results, down to %0d free slots,",
             n_requests, n_checked, min_free);
    $display("with %0d allocates on a full map and %0d frees of free slots.",
             n_no_free, n_double_free);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
